[design/hesc_pkg.sv]
// package of shared types and constants for the host event status controller
`timescale 1ns / 1ps

package hesc_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int QIDX_W   = 6;
    localparam int CFG_IDX_W = 2;

    // parameter defaults
    localparam int EVENT_WIDTH_DEF      = 32;
    localparam int POWER_BUTTON_BIT_DEF = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SMI_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCI_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_MASK = 2'd2;

    // input transaction
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] event_bits;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic              status_updated;
        logic              smi_pulse;
        logic              sci_pulse;
        logic              smi_pending;
        logic              sci_pending;
        logic              wake_low;
        logic [QIDX_W-1:0] query_index;
        logic [DATA_W-1:0] events_now;
    } t_out_item;

    // mask register set
    typedef struct packed {
        logic [DATA_W-1:0] smi;
        logic [DATA_W-1:0] sci;
        logic [DATA_W-1:0] wake;
    } t_masks;

    // held status flags
    typedef struct packed {
        logic smi_flag;
        logic sci_flag;
        logic wake_line;
    } t_status;

endpackage

[design/hesc_cfg_regs.sv]
// mask configuration registers with write decode
`timescale 1ns / 1ps

module hesc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hesc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hesc_pkg::DATA_W-1:0]    i_cfg_data,
    output hesc_pkg::t_masks               o_masks
);

    hesc_pkg::t_masks r_masks;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hesc_pkg::REG_SMI_MASK:  r_masks.smi  <= i_cfg_data;
                hesc_pkg::REG_SCI_MASK:  r_masks.sci  <= i_cfg_data;
                hesc_pkg::REG_WAKE_MASK: r_masks.wake <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_masks = r_masks;

endmodule

[design/hesc_eval.sv]
// next-state and result logic for one transaction
`timescale 1ns / 1ps

module hesc_eval #(
    parameter int EVENT_WIDTH      = hesc_pkg::EVENT_WIDTH_DEF,
    parameter int POWER_BUTTON_BIT = hesc_pkg::POWER_BUTTON_BIT_DEF
) (
    input  hesc_pkg::t_in_item        i_item,
    input  hesc_pkg::t_masks          i_masks,
    input  logic [EVENT_WIDTH-1:0]    i_pend,
    input  hesc_pkg::t_status         i_status,
    output logic [EVENT_WIDTH-1:0]    o_pend,
    output hesc_pkg::t_status         o_status,
    output hesc_pkg::t_out_item       o_result
);

    localparam int DW = hesc_pkg::DATA_W;

    logic [EVENT_WIDTH-1:0] bits_ev;
    logic [EVENT_WIDTH-1:0] smi_m;
    logic [EVENT_WIDTH-1:0] sci_m;
    logic [EVENT_WIDTH-1:0] wake_m;
    logic [EVENT_WIDTH-1:0] any_m;
    logic [EVENT_WIDTH-1:0] cand;
    logic [EVENT_WIDTH-1:0] low_one;
    logic [EVENT_WIDTH-1:0] n_pend;
    logic [EVENT_WIDTH-1:0] wake_set;
    logic [hesc_pkg::QIDX_W-1:0] q_enc;
    logic [hesc_pkg::QIDX_W-1:0] qidx;
    logic [DW-1:0]          events_out;
    logic                   updated;
    logic                   smi_any;
    logic                   sci_any;
    logic                   wake_any;

    // resize input word and masks to the event width
    for (genvar gi = 0; gi < EVENT_WIDTH; gi++) begin : g_resize
        if (gi < DW) begin : g_in
            assign bits_ev[gi] = i_item.event_bits[gi];
            assign smi_m[gi]   = i_masks.smi[gi];
            assign sci_m[gi]   = i_masks.sci[gi];
            assign wake_m[gi]  = i_masks.wake[gi];
        end else begin : g_out
            assign bits_ev[gi] = 1'b0;
            assign smi_m[gi]   = 1'b0;
            assign sci_m[gi]   = 1'b0;
            assign wake_m[gi]  = 1'b0;
        end
    end

    // pending word back to the 32-bit host view
    for (genvar go = 0; go < DW; go++) begin : g_mirror
        if (go < EVENT_WIDTH) begin : g_in
            assign events_out[go] = n_pend[go];
        end else begin : g_out
            assign events_out[go] = 1'b0;
        end
    end

    // lowest enabled pending bit, isolated as a one-hot word
    assign any_m   = smi_m | sci_m | wake_m;
    assign cand    = i_pend & any_m;
    assign low_one = cand & (~cand + EVENT_WIDTH'(1));

    // one-based index of the one-hot bit
    always_comb begin
        q_enc = '0;
        for (int i = 0; i < EVENT_WIDTH; i++) begin
            if (low_one[i]) begin
                q_enc = q_enc | hesc_pkg::QIDX_W'(i + 1);
            end
        end
    end

    // command decode
    always_comb begin
        n_pend  = i_pend;
        updated = 1'b0;
        qidx    = '0;
        case (i_item.command)
            hesc_pkg::CMD_SET: begin
                if (bits_ev != i_pend) begin
                    n_pend  = bits_ev;
                    updated = 1'b1;
                end
            end
            hesc_pkg::CMD_QUERY: begin
                // clear everything up to and including the found bit, all if none
                n_pend  = i_pend & ~(low_one | (low_one - EVENT_WIDTH'(1)));
                qidx    = q_enc;
                updated = 1'b1;
            end
            hesc_pkg::CMD_REFRESH: begin
                updated = 1'b1;
            end
            default: ;
        endcase
    end

    // status evaluation on the new pending word
    always_comb begin
        wake_set = n_pend & wake_m;
        if (POWER_BUTTON_BIT < EVENT_WIDTH) begin
            wake_set[POWER_BUTTON_BIT] = 1'b0;
        end
    end

    assign smi_any  = |(n_pend & smi_m);
    assign sci_any  = |(n_pend & sci_m);
    assign wake_any = |wake_set;

    always_comb begin
        o_status = i_status;
        o_result = '0;
        if (updated) begin
            o_status.smi_flag  = smi_any;
            o_status.sci_flag  = sci_any;
            o_status.wake_line = wake_any;
            o_result.smi_pulse = smi_any & ~i_status.smi_flag;
            o_result.sci_pulse = sci_any;
        end
        o_result.status_updated = updated;
        o_result.smi_pending    = o_status.smi_flag;
        o_result.sci_pending    = o_status.sci_flag;
        o_result.wake_low       = o_status.wake_line;
        o_result.query_index    = qidx;
        o_result.events_now     = events_out;
    end

    assign o_pend = n_pend;

endmodule

[design/host_event_status_controller.sv]
// top level: input register, event state, result register and handshakes
`timescale 1ns / 1ps

// Host event status controller. Takes one transaction per clock: a transaction
// accepted into the input register is evaluated against the pending event
// word and the SMI, SCI and wake masks, and its result is loaded into the
// output register when the output side can take it. The pending word and
// status flags update at that same edge, so a transaction directly behind it
// sees the new state; sustained throughput is one transaction per cycle,
// limited only by the output side stalling. Mask writes on the configuration
// port take effect at the next edge and do not themselves re-evaluate the
// status; send a refresh command afterwards.
module host_event_status_controller #(
    parameter int EVENT_WIDTH      = hesc_pkg::EVENT_WIDTH_DEF,
    parameter int POWER_BUTTON_BIT = hesc_pkg::POWER_BUTTON_BIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hesc_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hesc_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [hesc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hesc_pkg::DATA_W-1:0]    i_cfg_data
);

    hesc_pkg::t_masks       masks;
    hesc_pkg::t_in_item     r_in_data;
    logic                   r_in_valid;
    hesc_pkg::t_out_item    r_out_data;
    logic                   r_out_valid;
    logic [EVENT_WIDTH-1:0] r_pend;
    hesc_pkg::t_status      r_status;
    logic [EVENT_WIDTH-1:0] n_pend;
    hesc_pkg::t_status      n_status;
    hesc_pkg::t_out_item    n_out_data;
    logic                   out_ready;
    logic                   advance;
    logic                   in_accept;

    // mask registers
    hesc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_masks     (masks)
    );

    // evaluation logic
    hesc_eval #(
        .EVENT_WIDTH      (EVENT_WIDTH),
        .POWER_BUTTON_BIT (POWER_BUTTON_BIT)
    ) u_eval (
        .i_item   (r_in_data),
        .i_masks  (masks),
        .i_pend   (r_pend),
        .i_status (r_status),
        .o_pend   (n_pend),
        .o_status (n_status),
        .o_result (n_out_data)
    );

    // handshake control
    assign out_ready  = ~r_out_valid | ~i_out_stall;
    assign advance    = r_in_valid & out_ready;
    assign o_in_stall = r_in_valid & ~out_ready;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // event state, updated as each transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_status <= '0;
        end else if (advance) begin
            r_pend   <= n_pend;
            r_status <= n_status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an smi pulse always comes with the smi flag set
    a_smi_pulse_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.smi_pulse |-> r_out_data.smi_pending)
        else $error("smi pulse without smi pending");

    // pulses and query results only from an evaluation
    a_pulse_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.smi_pulse || r_out_data.sci_pulse ||
        r_out_data.query_index != '0) |-> r_out_data.status_updated)
        else $error("pulse or query index without evaluation");

    // on evaluation the sci pulse tracks the sci flag
    a_sci_pulse_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.status_updated |->
        r_out_data.sci_pulse == r_out_data.sci_pending)
        else $error("sci pulse disagrees with sci pending");

    // reported flags match the held state after each completed transaction
    a_flags_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_data.smi_pending == r_status.smi_flag &&
        r_out_data.sci_pending == r_status.sci_flag &&
        r_out_data.wake_low == r_status.wake_line)
        else $error("reported flags differ from held state");

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the host event status controller
`timescale 1ns / 1ps

module tb_top;

    localparam int          PB_BIT       = hesc_pkg::POWER_BUTTON_BIT_DEF;
    localparam logic [1:0]  CMD_NOP      = 2'd3;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          PRINT_LIMIT  = 50;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    hesc_pkg::t_in_item             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    hesc_pkg::t_out_item            out_data;
    logic                           cfg_we = 1'b0;
    logic [hesc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hesc_pkg::DATA_W-1:0]    cfg_data = '0;

    // stimulus and expectation stores
    hesc_pkg::t_in_item    cmd_q[$];
    hesc_pkg::t_out_item   status_q[$];
    hesc_pkg::t_out_item   status_front;

    // predictor state
    hesc_pkg::t_masks      mask_copy = '0;
    hesc_pkg::t_status     flag_copy = '0;
    logic [31:0]           events_copy = '0;

    // run control
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned recv_hold_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_ack = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned pushed_total = 0;
    logic [31:0] last_set_word = '0;

    host_event_status_controller DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock, 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // status evaluation and command handling of the block
    function automatic hesc_pkg::t_out_item predict_status(hesc_pkg::t_in_item it);
        hesc_pkg::t_out_item r;
        logic [31:0]         enabled;
        logic [31:0]         wake_set;
        logic                run_eval;
        logic                found;
        int                  b;
        r        = '0;
        run_eval = 1'b0;
        found    = 1'b0;
        case (it.command)
            hesc_pkg::CMD_SET: begin
                if (it.event_bits != events_copy) begin
                    events_copy = it.event_bits;
                    run_eval    = 1'b1;
                end
            end
            hesc_pkg::CMD_QUERY: begin
                // drop pending bits from the bottom until the first enabled one
                enabled = mask_copy.smi | mask_copy.sci | mask_copy.wake;
                for (b = 0; b < 32; b++) begin
                    if (!found && events_copy[b]) begin
                        events_copy[b] = 1'b0;
                        if (enabled[b]) begin
                            found         = 1'b1;
                            r.query_index = hesc_pkg::QIDX_W'(b + 1);
                        end
                    end
                end
                run_eval = 1'b1;
            end
            hesc_pkg::CMD_REFRESH: run_eval = 1'b1;
            default: ;
        endcase
        if (run_eval) begin
            r.status_updated = 1'b1;
            if ((events_copy & mask_copy.smi) != '0) begin
                r.smi_pulse        = !flag_copy.smi_flag;
                flag_copy.smi_flag = 1'b1;
            end else begin
                flag_copy.smi_flag = 1'b0;
            end
            r.sci_pulse        = (events_copy & mask_copy.sci) != '0;
            flag_copy.sci_flag = r.sci_pulse;
            // the power button never drives the wake line
            wake_set            = events_copy & mask_copy.wake;
            wake_set[PB_BIT]    = 1'b0;
            flag_copy.wake_line = wake_set != '0;
        end
        r.smi_pending = flag_copy.smi_flag;
        r.sci_pending = flag_copy.sci_flag;
        r.wake_low    = flag_copy.wake_line;
        r.events_now  = events_copy;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(string fname, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", fname, got, want));
    endtask

    task automatic check_result(hesc_pkg::t_out_item got, hesc_pkg::t_out_item want);
        compare_field("status_updated", 32'(got.status_updated), 32'(want.status_updated));
        compare_field("smi_pulse", 32'(got.smi_pulse), 32'(want.smi_pulse));
        compare_field("sci_pulse", 32'(got.sci_pulse), 32'(want.sci_pulse));
        compare_field("smi_pending", 32'(got.smi_pending), 32'(want.smi_pending));
        compare_field("sci_pending", 32'(got.sci_pending), 32'(want.sci_pending));
        compare_field("wake_low", 32'(got.wake_low), 32'(want.wake_low));
        compare_field("query_index", 32'(got.query_index), 32'(want.query_index));
        compare_field("events_now", got.events_now, want.events_now);
    endtask

    // driver: offers queued transactions, predicts each one on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                status_q.push_back(predict_status(in_data));
                void'(cmd_q.pop_front());
            end
            if (!in_valid || !in_stall) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= cmd_q[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every accepted result against the oldest expectation
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    status_front = status_q.pop_front();
                    check_result(out_data, status_front);
                end
            end
            out_stall <= (recv_hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge clk) begin
        if (recv_hold_left != 0) begin
            recv_hold_left <= recv_hold_left - 1;
        end else if (hold_req != hold_ack) begin
            recv_hold_left <= HOLD_CYCLES;
            hold_ack       <= hold_req;
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_cmd(logic [1:0] cmd, logic [31:0] bits);
        hesc_pkg::t_in_item it;
        it.command    = cmd;
        it.event_bits = bits;
        cmd_q.push_back(it);
        pushed_total++;
        if (cmd == hesc_pkg::CMD_SET)
            last_set_word = bits;
    endtask

    task automatic cfg_write(logic [hesc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            hesc_pkg::REG_SMI_MASK:  mask_copy.smi  = val;
            hesc_pkg::REG_SCI_MASK:  mask_copy.sci  = val;
            hesc_pkg::REG_WAKE_MASK: mask_copy.wake = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_masks(logic [31:0] smi, logic [31:0] sci, logic [31:0] wake);
        cfg_write(hesc_pkg::REG_SMI_MASK, smi);
        cfg_write(hesc_pkg::REG_SCI_MASK, sci);
        cfg_write(hesc_pkg::REG_WAKE_MASK, wake);
        @(negedge clk);
    endtask

    // wait until nothing is queued or outstanding, then let the pipeline settle
    task automatic drain_all();
        do @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || status_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom();
            3:       return 32'd1 << $urandom_range(31);
            4:       return last_set_word;
            5:       return last_set_word ^ (32'd1 << $urandom_range(31));
            default: return $urandom() & $urandom() & $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom();
            3:       return 32'd1 << $urandom_range(31);
            4:       return (32'd1 << PB_BIT) | (32'd1 << $urandom_range(31));
            default: return $urandom() & $urandom();
        endcase
    endfunction

    function automatic logic [1:0] pick_cmd();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return hesc_pkg::CMD_SET;
        else if (r < 80)
            return hesc_pkg::CMD_QUERY;
        else if (r < 95)
            return hesc_pkg::CMD_REFRESH;
        return CMD_NOP;
    endfunction

    // mostly post-and-walk sequences, the rest loose commands
    task automatic gen_random(int unsigned n);
        int unsigned stop_at;
        int unsigned walks;
        stop_at = pushed_total + n;
        while (pushed_total < stop_at) begin
            if ($urandom_range(99) < 60) begin
                push_cmd(hesc_pkg::CMD_SET, pick_word());
                walks = $urandom_range(5, 1);
                repeat (walks) push_cmd(hesc_pkg::CMD_QUERY, $urandom());
                if ($urandom_range(3) == 0)
                    push_cmd(hesc_pkg::CMD_REFRESH, $urandom());
            end else begin
                push_cmd(pick_cmd(), pick_word());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state: masks all clear
        push_cmd(hesc_pkg::CMD_QUERY, ALL_ONES);
        push_cmd(hesc_pkg::CMD_SET, '0);
        push_cmd(CMD_NOP, ALL_ONES);
        push_cmd(hesc_pkg::CMD_REFRESH, '0);
        drain_all();

        // single-bit masks, wake only on the power button
        set_masks(32'h0000_0001, 32'h8000_0000, 32'h0000_0004);
        push_cmd(hesc_pkg::CMD_SET, 32'h0000_0001);
        push_cmd(hesc_pkg::CMD_SET, 32'h0000_0003);
        push_cmd(hesc_pkg::CMD_SET, 32'h0000_0003);
        push_cmd(hesc_pkg::CMD_SET, 32'h0000_0004);
        push_cmd(hesc_pkg::CMD_SET, 32'h8000_0004);
        push_cmd(hesc_pkg::CMD_REFRESH, ALL_ONES);
        push_cmd(hesc_pkg::CMD_QUERY, '0);
        push_cmd(hesc_pkg::CMD_QUERY, '0);
        push_cmd(hesc_pkg::CMD_QUERY, '0);
        push_cmd(CMD_NOP, '0);
        drain_all();

        // everything enabled
        set_masks(ALL_ONES, ALL_ONES, ALL_ONES);
        push_cmd(hesc_pkg::CMD_SET, ALL_ONES);
        push_cmd(hesc_pkg::CMD_QUERY, '0);
        push_cmd(hesc_pkg::CMD_SET, 32'h0000_0004);
        push_cmd(hesc_pkg::CMD_SET, 32'h0000_000C);
        push_cmd(hesc_pkg::CMD_REFRESH, '0);
        push_cmd(hesc_pkg::CMD_SET, '0);
        drain_all();

        // random part under three idling regimes
        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin send_idle_pct = 32; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int sub = 0; sub < 4; sub++) begin
                set_masks(pick_mask(), pick_mask(), pick_mask());
                // receiver holds off while the sender keeps offering
                if (sub == 1)
                    hold_req = !hold_req;
                gen_random(160);
                drain_all();
            end
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
